/* sv/u2da_pkg.sv */
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package u2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int ROOM_W     = 16;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 4;

  localparam logic [3:0]        ASCII_DIGIT_HI = 4'h3;
  localparam logic [CHAR_W-1:0] CHAR_NONE      = 8'h00;

  // word moving through the shift-add-3 stages
  typedef struct packed {
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
    logic [ROOM_W-1:0]  room;
  } work_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][CHAR_W-1:0] chars;
    logic [COUNT_W-1:0]                digit_count;
    logic                              no_room;
  } result_t;

endpackage

/* sv/u2da_dabble.sv */
// ----------------------------------------------------------------------------
// u2da_dabble
// One pipeline stage of the shift-add-3 conversion: STEP_BITS binary bits are
// shifted into the BCD digits, with the add-3 correction before each shift.
// ----------------------------------------------------------------------------
module u2da_dabble #(
  parameter int STEP_BITS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  u2da_pkg::work_t in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output u2da_pkg::work_t out_word
);
  import u2da_pkg::*;

  work_t work_next;
  logic [VALUE_W-1:0] bin_w;
  logic [BCD_W-1:0]   bcd_w;

  always_comb begin
    bin_w = in_word.bin;
    bcd_w = in_word.bcd;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_w[4*d +: 4] >= 4'd5) begin
          bcd_w[4*d +: 4] = bcd_w[4*d +: 4] + 4'd3;
        end
      end
      {bcd_w, bin_w} = {bcd_w[BCD_W-2:0], bin_w, 1'b0};
    end
    work_next.bin  = bin_w;
    work_next.bcd  = bcd_w;
    work_next.room = in_word.room;
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_word <= work_next;
    end
  end

endmodule

/* sv/u2da_format.sv */
// ----------------------------------------------------------------------------
// u2da_format
// Last stage: finds the digit count, checks the buffer room, left-aligns the
// digits as ASCII and holds the result word in the output register.
// ----------------------------------------------------------------------------
module u2da_format (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  u2da_pkg::work_t   in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output u2da_pkg::result_t out_result
);
  import u2da_pkg::*;

  result_t            result_next;
  logic [3:0]         digit [NUM_DIGITS];
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] idx;
  logic               short_room;

  always_comb begin
    count = COUNT_W'(1);
    idx   = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      digit[d] = in_word.bcd[4*d +: 4];
      if (digit[d] != 4'd0) begin
        count = COUNT_W'(d + 1);
      end
    end
    short_room = in_word.room <= ROOM_W'(count);
    for (int k = 0; k < NUM_DIGITS; k++) begin
      result_next.chars[k] = CHAR_NONE;
      if (!short_room && (COUNT_W'(k) < count)) begin
        idx = count - COUNT_W'(1) - COUNT_W'(k);
        result_next.chars[k] = {ASCII_DIGIT_HI, digit[idx]};
      end
    end
    result_next.digit_count = short_room ? '0 : count;
    result_next.no_room     = short_room;
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_result <= result_next;
    end
  end

endmodule

/* sv/uint32_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// uint32_to_decimal_ascii
// Converts an unsigned 32-bit value to left-aligned decimal ASCII digits and
// checks that the destination buffer has room for them plus one byte.
//
//   channel | handshake           | word
//   --------+---------------------+------------------------------------------
//   in      | in_valid, in_stall  | value, room
//   out     | out_valid, out_stall| char_0..char_9, digit_count, no_room
//
// The pipeline takes one word per cycle while out is not stalled.
// The shift-add-3 stages take STEP_BITS bits each, then one format stage.
// Each stage holds one word and takes a new one when empty or moving on, so
// a stall on out backs up stage by stage and bubbles are squeezed out.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module uint32_to_decimal_ascii #(
  parameter int STEP_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  input  logic [15:0] room,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_0,
  output logic [7:0]  char_1,
  output logic [7:0]  char_2,
  output logic [7:0]  char_3,
  output logic [7:0]  char_4,
  output logic [7:0]  char_5,
  output logic [7:0]  char_6,
  output logic [7:0]  char_7,
  output logic [7:0]  char_8,
  output logic [7:0]  char_9,
  output logic [3:0]  digit_count,
  output logic        no_room
);
  import u2da_pkg::*;

  localparam int NUM_STAGES = VALUE_W / STEP_BITS;

  work_t   stage_word  [NUM_STAGES+1];
  logic    stage_valid [NUM_STAGES+1];
  logic    stage_stall [NUM_STAGES+1];
  result_t result;

  assign stage_word[0].bin  = value;
  assign stage_word[0].bcd  = '0;
  assign stage_word[0].room = room;
  assign stage_valid[0]     = in_valid;
  assign in_stall           = stage_stall[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    u2da_dabble #(
      .STEP_BITS(STEP_BITS)
    ) u_dabble (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stage_valid[g]),
      .in_stall (stage_stall[g]),
      .in_word  (stage_word[g]),
      .out_valid(stage_valid[g+1]),
      .out_stall(stage_stall[g+1]),
      .out_word (stage_word[g+1])
    );
  end

  u2da_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[NUM_STAGES]),
    .in_stall  (stage_stall[NUM_STAGES]),
    .in_word   (stage_word[NUM_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(result)
  );

  assign char_0      = result.chars[0];
  assign char_1      = result.chars[1];
  assign char_2      = result.chars[2];
  assign char_3      = result.chars[3];
  assign char_4      = result.chars[4];
  assign char_5      = result.chars[5];
  assign char_6      = result.chars[6];
  assign char_7      = result.chars[7];
  assign char_8      = result.chars[8];
  assign char_9      = result.chars[9];
  assign digit_count = result.digit_count;
  assign no_room     = result.no_room;

endmodule

/* sim/uint32_to_decimal_ascii_test.sv */
// ----------------------------------------------------------------------------
// uint32_to_decimal_ascii_test
// Self-checking bench for the binary to decimal ASCII converter. A driver
// feeds (value, room) words from a queue and a monitor compares every output
// word field by field against a behavioral formatter. Directed corner words
// come first, then random words aimed at every digit count and at the room
// boundary. The run cycles through idle/stall phases and drains between them.
// ----------------------------------------------------------------------------
module uint32_to_decimal_ascii_test;
  import u2da_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 20;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ROOM_W-1:0]  room;
  } conv_req_t;

  typedef struct {
    conv_req_t req;
    result_t   text;
  } pending_text_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        value = '0;
  logic [15:0]        room = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         char_0, char_1, char_2, char_3, char_4;
  logic [7:0]         char_5, char_6, char_7, char_8, char_9;
  logic [3:0]         digit_count;
  logic               no_room;
  wire  [CHAR_W-1:0]  seen_char [NUM_DIGITS];

  conv_req_t     conversions_todo[$];
  pending_text_t expected_text[$];
  pending_text_t want;
  conv_req_t     in_flight;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            failures = 0;
  int            cycles = 0;

  assign seen_char[0] = char_0;
  assign seen_char[1] = char_1;
  assign seen_char[2] = char_2;
  assign seen_char[3] = char_3;
  assign seen_char[4] = char_4;
  assign seen_char[5] = char_5;
  assign seen_char[6] = char_6;
  assign seen_char[7] = char_7;
  assign seen_char[8] = char_8;
  assign seen_char[9] = char_9;

  uint32_to_decimal_ascii i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_0     (char_0),
    .char_1     (char_1),
    .char_2     (char_2),
    .char_3     (char_3),
    .char_4     (char_4),
    .char_5     (char_5),
    .char_6     (char_6),
    .char_7     (char_7),
    .char_8     (char_8),
    .char_9     (char_9),
    .digit_count(digit_count),
    .no_room    (no_room)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // decimal text of v, left aligned; blank with no_room when it will not fit
  function automatic result_t decimal_text(input logic [VALUE_W-1:0] v,
                                           input logic [ROOM_W-1:0] space);
    result_t            r;
    logic [CHAR_W-1:0]  lsd_first [NUM_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n;
    r = '0;
    rest = v;
    n = 0;
    do begin
      lsd_first[n] = {ASCII_DIGIT_HI, 4'(rest % 10)};
      rest = rest / 10;
      n++;
    end while (rest != 0);
    if (int'(space) <= n) begin
      r.no_room = 1'b1;
    end else begin
      for (int k = 0; k < n; k++) r.chars[k] = lsd_first[n - 1 - k];
      r.digit_count = COUNT_W'(n);
    end
    return r;
  endfunction

  task automatic flag(input string msg);
    if (failures < MAX_PRINTS) $display("ERROR cycle %0d: %s", cycles, msg);
    failures++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_text.push_back('{in_flight, decimal_text(value, room)});
      end
      if (conversions_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_flight = conversions_todo.pop_front();
        in_valid <= 1'b1;
        value    <= in_flight.value;
        room     <= in_flight.room;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          flag("output word with nothing expected");
        end else begin
          want = expected_text.pop_front();
          for (int k = 0; k < NUM_DIGITS; k++) begin
            if (seen_char[k] !== want.text.chars[k])
              flag($sformatf("value %0d room %0d: char_%0d got %02h want %02h",
                             want.req.value, want.req.room, k, seen_char[k],
                             want.text.chars[k]));
          end
          if (digit_count !== want.text.digit_count)
            flag($sformatf("value %0d room %0d: digit_count got %0d want %0d",
                           want.req.value, want.req.room, digit_count,
                           want.text.digit_count));
          if (no_room !== want.text.no_room)
            flag($sformatf("value %0d room %0d: no_room got %0b want %0b",
                           want.req.value, want.req.room, no_room,
                           want.text.no_room));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic add_conv(input logic [31:0] v, input logic [15:0] space);
    conversions_todo.push_back('{v, space});
  endtask

  // random words: mostly a chosen digit count with room near the boundary
  task automatic add_random(input int count);
    longint      lo, hi;
    logic [31:0] v;
    logic [15:0] space;
    int          d, n;
    for (int i = 0; i < count; i++) begin
      d = $urandom_range(10, 1);
      lo = 1;
      repeat (d - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      if (d == 1) lo = 0;
      case ($urandom_range(9))
        0:       v = lo;
        1:       v = hi;
        2, 3:    v = $urandom;
        default: v = 32'(lo + longint'($urandom) % (hi - lo + 1));
      endcase
      n = int'(decimal_text(v, '1).digit_count);
      case ($urandom_range(9))
        0:       space = 16'($urandom_range(65535));
        1:       space = '1;
        2:       space = '0;
        default: space = 16'(n - 1 + $urandom_range(3));
      endcase
      add_conv(v, space);
    end
  endtask

  task automatic drain();
    while (conversions_todo.size() != 0 || in_valid || expected_text.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    while (rst) @(negedge clk);

    add_conv(32'd0, 16'd0);
    add_conv(32'd0, 16'd1);
    add_conv(32'd0, 16'd2);
    add_conv(32'd0, 16'hFFFF);
    add_conv(32'd1, 16'd1);
    add_conv(32'd9, 16'd2);
    add_conv(32'd10, 16'd2);
    add_conv(32'd10, 16'd3);
    add_conv(32'd99, 16'd3);
    add_conv(32'd100, 16'd3);
    add_conv(32'd100, 16'd4);
    add_conv(32'd123456789, 16'd10);
    add_conv(32'd999999999, 16'd9);
    add_conv(32'd999999999, 16'd10);
    add_conv(32'd1000000000, 16'd10);
    add_conv(32'd1000000000, 16'd11);
    add_conv(32'h8000_0000, 16'd11);
    add_conv(32'hFFFF_FFFF, 16'd0);
    add_conv(32'hFFFF_FFFF, 16'd10);
    add_conv(32'hFFFF_FFFF, 16'd11);
    add_conv(32'hFFFF_FFFF, 16'hFFFF);
    add_conv(32'd7, 16'h8000);
    drain();

    for (int round = 0; round < 2; round++) begin
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        add_random(110);
        drain();
      end
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_text.size() != 0) flag("expected words never arrived");
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/u2da_pkg.sv
sv/u2da_dabble.sv
sv/u2da_format.sv
sv/uint32_to_decimal_ascii.sv
sim/uint32_to_decimal_ascii_test.sv
